// File: rtl/chr_pkg.sv
`default_nettype none
package chr_pkg;

  localparam int PHASE_W = 32;
  localparam int FRAC_BITS = 24;
  localparam logic [PHASE_W-1:0] PHASE_ONE = 32'h4000_0000;
  localparam logic [PHASE_W-1:0] RATIO_RESET = 32'd779132837;

endpackage
`default_nettype wire

// File: rtl/cubic_hermite_resampler_top.sv
`default_nettype none
// Channel | Direction | Content
// in_     | slave     | tdata = left, right (source stereo sample)
// out_    | master    | tdata = left, right; tlast = last output for this input item
// cfg_    | write     | data = rate ratio, unsigned Q2.30
//
// Each output is computed by the Horner sequencer in each lane
// (three multiply/add passes).
// Up to MAX_RUN outputs per input item. in_tready is low while a run is in progress.
// rst_n is synchronous; it clears control state and loads the ratio reset value.
// A stalled output holds in the output register; the next result waits in the lanes.
module cubic_hermite_resampler_top #(
  parameter int SAMPLE_WIDTH = 24,
  parameter int MAX_RUN = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // [SW-1:0] in_left, [2SW-1:SW] in_right, zero padded to bytes
  input  wire logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // [SW-1:0] out_left, [2SW-1:SW] out_right, zero padded to bytes
  output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] out_tdata,
  output logic                       out_tlast,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [31:0]           cfg_data
);
  import chr_pkg::*;

  localparam int DATA_W = ((2*SAMPLE_WIDTH+7)/8)*8;
  localparam int CNT_W = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CALC = 3'b010,
    S_PUSH = 3'b100
  } ctl_state_t;

  ctl_state_t state_r, state_nxt;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [PHASE_W-1:0] ratio_r;
  logic [2:0] fill_r, fill_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [3:0][SAMPLE_WIDTH-1:0] win_l_r, win_rt_r;
  logic [3:0][SAMPLE_WIDTH-1:0] win_l_nxt, win_rt_nxt;

  logic [SAMPLE_WIDTH-1:0] in_l, in_rt;
  logic in_acc;
  logic lane_start;
  logic done_l, done_rt;
  logic [SAMPLE_WIDTH-1:0] res_l, res_rt;
  logic slot_free;
  logic push;
  logic push_last;
  logic [PHASE_W:0] sum;
  logic reached;
  logic cap;

  assign in_l = in_tdata[SAMPLE_WIDTH-1:0];
  assign in_rt = in_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
  assign in_tready = (state_r == S_IDLE);
  assign in_acc = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign sum = {1'b0, phase_r} + {1'b0, ratio_r};
  assign reached = (sum >= {1'b0, PHASE_ONE});
  assign cap = (cnt_r == CNT_W'(MAX_RUN - 1));
  assign push_last = reached || cap;
  assign push = (state_r == S_PUSH) && slot_free;

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    fill_nxt = fill_r;
    cnt_nxt = cnt_r;
    lane_start = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (fill_r < 3'd4) begin
            fill_nxt = fill_r + 3'd1;
            if (fill_r == 3'd3) begin
              phase_nxt = '0;
              cnt_nxt = '0;
              lane_start = 1'b1;
              state_nxt = S_CALC;
            end
          end else if (phase_r >= PHASE_ONE) begin
            phase_nxt = phase_r - PHASE_ONE;
          end else begin
            cnt_nxt = '0;
            lane_start = 1'b1;
            state_nxt = S_CALC;
          end
        end
      end
      S_CALC: begin
        if (done_l && done_rt) begin
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        if (slot_free) begin
          if (reached) begin
            phase_nxt = sum[PHASE_W-1:0] - PHASE_ONE;
          end else if (cap) begin
            phase_nxt = '0;
          end else begin
            phase_nxt = sum[PHASE_W-1:0];
          end
          if (push_last) begin
            state_nxt = S_IDLE;
          end else begin
            cnt_nxt = cnt_r + CNT_W'(1);
            lane_start = 1'b1;
            state_nxt = S_CALC;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= '0;
      fill_r <= '0;
      cnt_r <= '0;
      ratio_r <= RATIO_RESET;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      fill_r <= fill_nxt;
      cnt_r <= cnt_nxt;
      if (cfg_valid && cfg_ready) begin
        ratio_r <= cfg_data;
      end
    end
  end

  always_comb begin
    win_l_nxt = win_l_r;
    win_rt_nxt = win_rt_r;
    if (in_acc) begin
      if (fill_r < 3'd4) begin
        win_l_nxt[fill_r[1:0]] = in_l;
        win_rt_nxt[fill_r[1:0]] = in_rt;
      end else begin
        win_l_nxt = {in_l, win_l_r[3:1]};
        win_rt_nxt = {in_rt, win_rt_r[3:1]};
      end
    end
  end

  always_ff @(posedge clk) begin
    win_l_r <= win_l_nxt;
    win_rt_r <= win_rt_nxt;
  end

  chr_lane #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_lane_l (
    .clk   (clk),
    .rst_n (rst_n),
    .start (lane_start),
    .taps  (win_l_nxt),
    .t_in  (phase_nxt[PHASE_W-3 -: FRAC_BITS]),
    .res   (res_l),
    .done  (done_l)
  );

  chr_lane #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_lane_r (
    .clk   (clk),
    .rst_n (rst_n),
    .start (lane_start),
    .taps  (win_rt_nxt),
    .t_in  (phase_nxt[PHASE_W-3 -: FRAC_BITS]),
    .res   (res_rt),
    .done  (done_rt)
  );

  chr_merge #(.SAMPLE_WIDTH(SAMPLE_WIDTH), .DATA_W(DATA_W)) u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .left       (res_l),
    .right      (res_rt),
    .last       (push_last),
    .slot_free  (slot_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

// File: rtl/chr_lane.sv
`default_nettype none
module chr_lane #(
  parameter int SAMPLE_WIDTH = 24
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  input  wire logic [3:0][SAMPLE_WIDTH-1:0]      taps,
  input  wire logic [chr_pkg::FRAC_BITS-1:0]     t_in,
  output logic [SAMPLE_WIDTH-1:0]                res,
  output logic                                   done
);
  import chr_pkg::*;

  localparam int ACC_W = SAMPLE_WIDTH + 5;
  localparam int PROD_W = ACC_W + FRAC_BITS + 1;

  typedef enum logic [4:0] {
    L_IDLE = 5'b00001,
    L_MUL  = 5'b00010,
    L_ADD  = 5'b00100,
    L_RND  = 5'b01000,
    L_DONE = 5'b10000
  } lane_state_t;

  lane_state_t state_r, state_nxt;
  logic [1:0] step_r, step_nxt;

  logic signed [ACC_W-1:0] b2_r, c2_r, d2_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [FRAC_BITS-1:0] t_r;
  logic [SAMPLE_WIDTH-1:0] res_r;

  logic signed [ACC_W-1:0] x0, x1, x2, x3;
  logic signed [ACC_W-1:0] a2, b2, c2, d2;
  logic signed [ACC_W-1:0] coef;
  logic signed [ACC_W-1:0] acc_next;
  logic signed [ACC_W-1:0] rnd_sum;
  logic signed [ACC_W-2:0] half;
  logic signed [ACC_W-2:0] hi_lim, lo_lim;
  logic [SAMPLE_WIDTH-1:0] sat;

  assign x0 = ACC_W'($signed(taps[0]));
  assign x1 = ACC_W'($signed(taps[1]));
  assign x2 = ACC_W'($signed(taps[2]));
  assign x3 = ACC_W'($signed(taps[3]));

  assign a2 = x3 - x0 + ((x1 - x2) <<< 1) + (x1 - x2);
  assign b2 = (x0 <<< 1) - (x1 <<< 2) - x1 + (x2 <<< 2) - x3;
  assign c2 = x2 - x0;
  assign d2 = x1 <<< 1;

  always_comb begin
    case (step_r)
      2'd0:    coef = b2_r;
      2'd1:    coef = c2_r;
      default: coef = d2_r;
    endcase
  end

  // floor(prod / 2^FRAC_BITS)
  assign acc_next = coef + $signed(prod_r[FRAC_BITS +: ACC_W]);

  assign rnd_sum = acc_r + ACC_W'(1);
  assign half = rnd_sum[ACC_W-1:1];
  assign hi_lim = (ACC_W-1)'($signed({1'b0, {(SAMPLE_WIDTH-1){1'b1}}}));
  assign lo_lim = (ACC_W-1)'($signed({1'b1, {(SAMPLE_WIDTH-1){1'b0}}}));

  always_comb begin
    if (half > hi_lim) begin
      sat = hi_lim[SAMPLE_WIDTH-1:0];
    end else if (half < lo_lim) begin
      sat = lo_lim[SAMPLE_WIDTH-1:0];
    end else begin
      sat = half[SAMPLE_WIDTH-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt = step_r;
    case (state_r)
      L_IDLE: state_nxt = L_IDLE;
      L_MUL:  state_nxt = L_ADD;
      L_ADD: begin
        if (step_r == 2'd2) begin
          state_nxt = L_RND;
        end else begin
          step_nxt = step_r + 2'd1;
          state_nxt = L_MUL;
        end
      end
      L_RND:  state_nxt = L_DONE;
      L_DONE: state_nxt = L_DONE;
      default: state_nxt = L_IDLE;
    endcase
    if (start) begin
      state_nxt = L_MUL;
      step_nxt = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
      step_r <= 2'd0;
    end else begin
      state_r <= state_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= a2;
      b2_r <= b2;
      c2_r <= c2;
      d2_r <= d2;
      t_r <= t_in;
    end else if (state_r == L_ADD) begin
      acc_r <= acc_next;
    end
    if (state_r == L_MUL) begin
      prod_r <= PROD_W'(acc_r) * $signed({1'b0, t_r});
    end
    if (state_r == L_RND) begin
      res_r <= sat;
    end
  end

  assign res = res_r;
  assign done = (state_r == L_DONE);

endmodule
`default_nettype wire

// File: rtl/chr_merge.sv
`default_nettype none
module chr_merge #(
  parameter int SAMPLE_WIDTH = 24,
  parameter int DATA_W = 48
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    push,
  input  wire logic [SAMPLE_WIDTH-1:0] left,
  input  wire logic [SAMPLE_WIDTH-1:0] right,
  input  wire logic                    last,
  output logic                         slot_free,
  output logic                         out_tvalid,
  input  wire logic                    out_tready,
  output logic [DATA_W-1:0]            out_tdata,
  output logic                         out_tlast
);

  logic valid_r;
  logic [DATA_W-1:0] data_r;
  logic last_r;

  assign slot_free = !valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (push) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data_r <= DATA_W'({right, left});
      last_r <= last;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata = data_r;
  assign out_tlast = last_r;

endmodule
`default_nettype wire

// File: dv/testbench.sv
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import chr_pkg::*;

  localparam int SW = 24;
  localparam int MAX_RUN = 16;
  localparam int DATA_W = ((2*SW+7)/8)*8;
  localparam int LIMIT_CYCLES = 400000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES = 400;
  localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};
  localparam logic [31:0] RATIO_MIN = 32'h0400_0000;

  typedef enum int {IDLE_SLOW_SINK, IDLE_SLOW_SOURCE, IDLE_NONE} idle_mode_t;

  typedef struct packed {
    logic signed [SW-1:0] left;
    logic signed [SW-1:0] right;
    logic                 last;
  } stereo_out_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [DATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [DATA_W-1:0] out_tdata;
  logic out_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [31:0] cfg_data = '0;

  cubic_hermite_resampler_top #(.SAMPLE_WIDTH(SW), .MAX_RUN(MAX_RUN)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // predictor state
  longint taps_l [4];
  longint taps_r [4];
  logic [31:0] phase_acc;
  int primed_count;
  logic [31:0] step_ratio;

  logic [DATA_W-1:0] source_items [$];
  stereo_out_t pending_outputs [$];
  int queued_count = 0;
  int accepted_count = 0;
  int errors = 0;
  int cycle_count = 0;
  int in_idle_pct = 0;
  int out_idle_pct = 0;
  logic in_taken = 1'b0;
  logic cfg_done = 1'b0;
  logic out_hold = 1'b0;
  bit hold_go = 1'b0;
  longint walk_l = 0;
  longint walk_r = 0;

  logic signed [SW-1:0] dir_l [18] = '{0, S_MAX, S_MIN, S_MAX, S_MIN, S_MIN, S_MAX, S_MAX,
                                       S_MIN, S_MIN, 1, -1, 0, S_MAX, S_MAX, S_MIN, S_MIN,
                                       24'h555555};
  logic signed [SW-1:0] dir_r [18] = '{0, S_MIN, S_MAX, S_MAX, S_MIN, S_MAX, S_MIN, S_MIN,
                                       S_MAX, S_MAX, -1, 1, 0, S_MIN, S_MIN, S_MAX, S_MAX,
                                       24'haaaaaa};

  function automatic logic signed [SW-1:0] clip_sample(input longint v);
    longint hi;
    longint lo;
    hi = longint'(S_MAX);
    lo = longint'(S_MIN);
    if (v > hi) return S_MAX;
    if (v < lo) return S_MIN;
    return v[SW-1:0];
  endfunction

  // Catmull-Rom on doubled coefficients, Horner in t (24 fractional bits)
  function automatic logic signed [SW-1:0] cubic_point(input longint x [4], input longint t);
    longint acc;
    acc = -x[0] + 3*x[1] - 3*x[2] + x[3];
    acc = (2*x[0] - 5*x[1] + 4*x[2] - x[3]) + ((acc * t) >>> FRAC_BITS);
    acc = (x[2] - x[0]) + ((acc * t) >>> FRAC_BITS);
    acc = 2*x[1] + ((acc * t) >>> FRAC_BITS);
    return clip_sample((acc + 1) >>> 1);
  endfunction

  task automatic resample_input(input logic [DATA_W-1:0] d);
    longint sl;
    longint sr;
    longint t;
    logic [32:0] sum;
    stereo_out_t o;
    int n;
    bit done;
    sl = longint'(signed'(d[SW-1:0]));
    sr = longint'(signed'(d[2*SW-1:SW]));
    if (primed_count < 4) begin
      taps_l[primed_count] = sl;
      taps_r[primed_count] = sr;
      primed_count++;
      if (primed_count < 4) return;
      phase_acc = '0;
    end else begin
      for (int k = 0; k < 3; k++) begin
        taps_l[k] = taps_l[k+1];
        taps_r[k] = taps_r[k+1];
      end
      taps_l[3] = sl;
      taps_r[3] = sr;
      if (phase_acc >= PHASE_ONE) begin
        phase_acc = phase_acc - PHASE_ONE;
        return;
      end
    end
    n = 0;
    done = 1'b0;
    while (!done) begin
      t = longint'(phase_acc >> (30 - FRAC_BITS));
      o.left = cubic_point(taps_l, t);
      o.right = cubic_point(taps_r, t);
      n++;
      sum = {1'b0, phase_acc} + {1'b0, step_ratio};
      if (sum >= {1'b0, PHASE_ONE}) begin
        phase_acc = 32'(sum - {1'b0, PHASE_ONE});
        done = 1'b1;
      end else begin
        phase_acc = sum[31:0];
        if (n >= MAX_RUN) begin
          phase_acc = '0;
          done = 1'b1;
        end
      end
      o.last = done;
      pending_outputs.push_back(o);
    end
  endtask

  // sample side: prediction on accepted items, checks on results
  always @(posedge clk) begin
    stereo_out_t want;
    logic signed [SW-1:0] got_l;
    logic signed [SW-1:0] got_r;
    if (!rst_n) begin
      for (int k = 0; k < 4; k++) begin
        taps_l[k] = 0;
        taps_r[k] = 0;
      end
      phase_acc = '0;
      primed_count = 0;
      step_ratio = RATIO_RESET;
      in_taken <= 1'b0;
      cfg_done <= 1'b0;
    end else begin
      in_taken <= in_tvalid && in_tready;
      cfg_done <= cfg_valid && cfg_ready;
      if (cfg_valid && cfg_ready) step_ratio = cfg_data;
      if (in_tvalid && in_tready) begin
        resample_input(in_tdata);
        accepted_count++;
      end
      if (out_tvalid && out_tready) begin
        got_l = out_tdata[SW-1:0];
        got_r = out_tdata[2*SW-1:SW];
        if (pending_outputs.size() == 0) begin
          $display("%0t: unexpected item left=%0d right=%0d last=%0b",
                   $time, got_l, got_r, out_tlast);
          errors++;
        end else begin
          want = pending_outputs.pop_front();
          if (got_l !== want.left) begin
            $display("%0t: out_left expected %0d got %0d", $time, want.left, got_l);
            errors++;
          end
          if (got_r !== want.right) begin
            $display("%0t: out_right expected %0d got %0d", $time, want.right, got_r);
            errors++;
          end
          if (out_tlast !== want.last) begin
            $display("%0t: out_tlast expected %0b got %0b", $time, want.last, out_tlast);
            errors++;
          end
        end
      end
    end
  end

  // source driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      if (source_items.size() > 0 && $urandom_range(99) >= in_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata <= source_items.pop_front();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // sink
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= !out_hold && ($urandom_range(99) >= out_idle_pct);
    end
  end

  // long back-pressure stretch
  initial begin
    wait (hold_go);
    @(negedge clk);
    out_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    out_hold <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("cubic_hermite_resampler_top regression: fail");
      $finish;
    end
  end

  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_SLOW_SINK: begin
        in_idle_pct = 35;
        out_idle_pct = 71;
      end
      IDLE_SLOW_SOURCE: begin
        in_idle_pct = 71;
        out_idle_pct = 35;
      end
      default: begin
        in_idle_pct = 0;
        out_idle_pct = 0;
      end
    endcase
  endtask

  task automatic write_ratio(input logic [31:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(negedge clk); while (!cfg_done);
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_item(input logic signed [SW-1:0] l, input logic signed [SW-1:0] r);
    logic [DATA_W-1:0] d;
    d = '0;
    d[SW-1:0] = l;
    d[2*SW-1:SW] = r;
    source_items.push_back(d);
    queued_count++;
  endtask

  function automatic logic signed [SW-1:0] corner_value();
    case ($urandom_range(3))
      0: return S_MAX;
      1: return S_MIN;
      2: return '0;
      default: return '1;
    endcase
  endfunction

  // smooth audio-like walks for half the items, the rest full-range noise and rail, zero or all-ones values
  task automatic queue_random(input int count);
    int style;
    @(posedge clk);
    for (int i = 0; i < count; i++) begin
      style = $urandom_range(99);
      if (style < 50) begin
        walk_l = clip_sample(walk_l + longint'($urandom_range(131072)) - 65536);
        walk_r = clip_sample(walk_r + longint'($urandom_range(1048576)) - 524288);
        queue_item(walk_l[SW-1:0], walk_r[SW-1:0]);
      end else if (style < 80) begin
        queue_item(SW'($urandom), SW'($urandom));
      end else begin
        queue_item(corner_value(), corner_value());
      end
    end
  endtask

  task automatic drain();
    do @(negedge clk);
    while (accepted_count != queued_count || pending_outputs.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // reset ratio, priming and saturating shapes
    set_idling(IDLE_SLOW_SINK);
    @(posedge clk);
    for (int i = 0; i < 18; i++) queue_item(dir_l[i], dir_r[i]);
    drain();

    write_ratio(RATIO_MIN);
    queue_random(14);
    drain();

    set_idling(IDLE_SLOW_SOURCE);
    write_ratio(32'hFFFF_FFFF);
    queue_random(24);
    drain();

    write_ratio(PHASE_ONE);
    queue_random(14);
    drain();

    // zero ratio: every run ends on the cap
    write_ratio(32'h0000_0000);
    queue_random(8);
    drain();

    set_idling(IDLE_NONE);
    write_ratio($urandom_range(32'h1000_0000, RATIO_MIN));
    hold_go = 1'b1;
    queue_random(30);
    drain();

    write_ratio($urandom);
    queue_random(26);
    drain();

    write_ratio($urandom_range(PHASE_ONE, RATIO_MIN));
    queue_random(26);
    drain();

    repeat (200) @(negedge clk);
    if (errors == 0) begin
      $display("cubic_hermite_resampler_top regression: pass");
    end else begin
      $display("cubic_hermite_resampler_top regression: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
